// File: rtl/byte_queue_with_positional_insert_assert.svh
// Assertion macros used by the checker module of the byte queue.
// No dependencies; include by bare file name.
`ifndef BYTE_QUEUE_WITH_POSITIONAL_INSERT_ASSERT_SVH
`define BYTE_QUEUE_WITH_POSITIONAL_INSERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held low.
`define BQI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define BQI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bqi_pkg.sv
// Shared types and constants of the byte queue with positional insert.
// No dependencies.
package bqi_pkg;

    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int CNT_OUT_W = 5;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] position;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0]    head_byte;
        logic                 empty_res;
        logic [CNT_OUT_W-1:0] entries;
        logic                 rejected;
    } t_result;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_seq_stat;

endpackage

// File: rtl/bqi_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on bqi_pkg.
interface bqi_in_if import bqi_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface bqi_out_if import bqi_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    head_byte;
    logic                 empty_res;
    logic [CNT_OUT_W-1:0] entries;
    logic                 rejected;

    modport source (output valid, output head_byte, output empty_res, output entries,
                    output rejected, input ready);
    modport sink   (input valid, input head_byte, input empty_res, input entries,
                    input rejected, output ready);
endinterface

// File: rtl/bqi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bqi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bqi_idx_unit.sv
// Shared index step unit: one add/subtract of the slot index and the end compare.
// No package dependencies.
module bqi_idx_unit #(
    parameter int DEPTH = 16
) (
    input  logic [$clog2(DEPTH)-1:0]   i_idx,
    input  logic                       i_down,
    input  logic [$clog2(DEPTH)-1:0]   i_where,
    input  logic [$clog2(DEPTH+1)-1:0] i_fill,
    output logic [$clog2(DEPTH)-1:0]   o_idx_m1,
    output logic [$clog2(DEPTH)-1:0]   o_idx_next,
    output logic                       o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] sum;

    // Step toward the rear when draining the front, toward the front when opening a gap.
    assign sum        = CW'(i_idx) + (i_down ? CW'(1) : {CW{1'b1}});
    assign o_idx_next = sum[AW-1:0];
    assign o_idx_m1   = i_idx - AW'(1);
    assign o_last     = i_down ? (sum == i_fill) : (sum == CW'(i_where));

endmodule

// File: rtl/bqi_seq.sv
// Sequencer of the byte queue: moves slots one at a time through the RAM port.
// Depends on bqi_pkg and bqi_idx_unit.
module bqi_seq import bqi_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_item                    i_item,
    input  logic                     i_out_free,
    output t_seq_stat                o_stat,
    output t_result                  o_result,
    output logic                     o_ram_we,
    output logic [$clog2(DEPTH)-1:0] o_ram_waddr,
    output logic [BYTE_W-1:0]        o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0] o_ram_raddr,
    input  logic [BYTE_W-1:0]        i_ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > BYTE_W) ? CW : BYTE_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_where, n_where;
    logic              r_down, n_down;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_rej, n_rej;
    logic [BYTE_W-1:0] r_head, n_head;

    logic [AW-1:0] idx_m1;
    logic [AW-1:0] idx_next;
    logic          idx_last;
    logic          full;
    logic [AW-1:0] where_sel;

    bqi_idx_unit #(.DEPTH(DEPTH)) u_idx (
        .i_idx      (r_idx),
        .i_down     (r_down),
        .i_where    (r_where),
        .i_fill     (r_fill),
        .o_idx_m1   (idx_m1),
        .o_idx_next (idx_next),
        .o_last     (idx_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_where <= n_where;
        r_down  <= n_down;
        r_byte  <= n_byte;
        r_rej   <= n_rej;
        r_head  <= n_head;
    end

    assign full = (r_fill == CW'(DEPTH));

    always_comb begin
        case (i_item.op)
            OP_FRONT:  where_sel = '0;
            OP_INSERT: where_sel = (PW'(i_item.position) >= PW'(r_fill)) ? AW'(r_fill)
                                                                          : AW'(i_item.position);
            default:   where_sel = AW'(r_fill);
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_where     = r_where;
        n_down      = r_down;
        n_byte      = r_byte;
        n_rej       = r_rej;
        n_head      = r_head;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        o_ram_wdata = i_ram_rdata;
        o_ram_raddr = '0;
        o_stat      = '{idle: 1'b0, res_valid: 1'b0};

        case (r_state)
            S_IDLE: begin
                o_stat.idle = 1'b1;
                if (i_start) begin
                    n_rej   = 1'b0;
                    n_byte  = i_item.value;
                    n_down  = 1'b0;
                    n_state = S_HEAD_RD;
                    case (i_item.op)
                        OP_APPEND, OP_FRONT, OP_INSERT: begin
                            if (full) begin
                                n_rej = 1'b1;
                            end else begin
                                n_where = where_sel;
                                n_idx   = AW'(r_fill);
                                n_state = (CW'(where_sel) == r_fill) ? S_PLACE : S_SHIFT_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_fill == CW'(1)) begin
                                n_fill = '0;
                            end else if (r_fill != '0) begin
                                n_down  = 1'b1;
                                n_idx   = AW'(1);
                                n_state = S_SHIFT_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT_RD: begin
                o_ram_raddr = r_down ? r_idx : idx_m1;
                n_state     = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_down ? idx_m1 : r_idx;
                o_ram_wdata = i_ram_rdata;
                n_idx       = idx_next;
                if (!idx_last) begin
                    n_state = S_SHIFT_RD;
                end else if (r_down) begin
                    n_fill  = r_fill - CW'(1);
                    n_state = S_HEAD_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_where;
                o_ram_wdata = r_byte;
                n_fill      = r_fill + CW'(1);
                n_state     = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                n_state = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                n_head  = (r_fill != '0) ? i_ram_rdata : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_stat.res_valid = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result = '{
        head_byte: r_head,
        empty_res: (r_fill == '0),
        entries:   CNT_OUT_W'(r_fill),
        rejected:  r_rej
    };

endmodule

// File: rtl/byte_queue_with_positional_insert.sv
// Byte queue with positional insert: one word in, one result word out, n = count.
// Accepted insert at p (p clipped to n): slots p..n-1 each move up one by a read/write
// pair, then the byte is placed; remove moves slots 1..n-1 down the same way (n > 1);
// every word ends with a read of the front slot. Slot moves share the single RAM port;
// a full output register holds the result back. Next word accepted in the cycle after hand-off.
// Reset (i_rst_n low, synchronous): count cleared, sequencer idle, output empty.
module byte_queue_with_positional_insert import bqi_pkg::*; #(
    parameter int DEPTH = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    bqi_in_if.sink    i_in,
    bqi_out_if.source o_out
);

    localparam int AW = $clog2(DEPTH);

    t_seq_stat         seq_stat;
    t_result           seq_result;
    t_item             item;
    logic              start;
    logic              out_free;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic    r_out_valid;
    t_result r_out;

    // Take a word only while the sequencer sits idle; it holds the whole operation.
    assign i_in.ready = seq_stat.idle;
    assign start      = i_in.valid && seq_stat.idle;
    assign item       = '{op: i_in.op, value: i_in.value, position: i_in.position};

    // The output register is free when empty or drained in this same cycle.
    assign out_free = !r_out_valid || o_out.ready;

    bqi_seq #(.DEPTH(DEPTH)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (item),
        .i_out_free  (out_free),
        .o_stat      (seq_stat),
        .o_result    (seq_result),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Slot store: slot 0 is the front; only slots below the count are ever read back.
    bqi_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register: load on a finished result, drop once the sink takes the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.res_valid) begin
            r_out <= seq_result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.head_byte = r_out.head_byte;
    assign o_out.empty_res = r_out.empty_res;
    assign o_out.entries   = r_out.entries;
    assign o_out.rejected  = r_out.rejected;

endmodule

// File: rtl/bqi_checker.sv
// Port-level checks for the byte queue, attached to the top level by bind.
// Depends on byte_queue_with_positional_insert_assert.svh and the top level.
`include "byte_queue_with_positional_insert_assert.svh"

module bqi_checker #(
    parameter int DEPTH = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_head_byte,
    input logic       i_out_empty_res,
    input logic [4:0] i_out_entries,
    input logic       i_out_rejected
);

    localparam logic [4:0] FULL_CNT = 5'(DEPTH);

    `BQI_ASSERT_IMP(a_empty_matches_count, i_clk, i_rst_n, i_out_valid, i_out_empty_res == (i_out_entries == 5'd0), "empty flag disagrees with count")
    `BQI_ASSERT_IMP(a_empty_head_zero, i_clk, i_rst_n, i_out_valid && i_out_empty_res, i_out_head_byte == 8'd0, "empty queue reports nonzero front byte")
    `BQI_ASSERT_IMP(a_reject_only_full, i_clk, i_rst_n, i_out_valid && i_out_rejected, i_out_entries == FULL_CNT && !i_out_empty_res, "refused insert on a queue that is not full")
    `BQI_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready held high while a word is in work")
    `BQI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_entries) && $stable(i_out_head_byte) && $stable(i_out_rejected), "stalled result word changed")

endmodule

bind byte_queue_with_positional_insert bqi_checker #(.DEPTH(DEPTH)) u_bqi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_head_byte (o_out.head_byte),
    .i_out_empty_res (o_out.empty_res),
    .i_out_entries   (o_out.entries),
    .i_out_rejected  (o_out.rejected)
);

// File: tb/testbench.sv
// Self-checking bench for byte_queue_with_positional_insert: directed and random queue words.
// Expected status words come from a behavioral copy of the queue kept here.
// Depends on bqi_pkg, the bqi_if channel interfaces and the RTL top level.
module testbench import bqi_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_WORDS  = 515;
    localparam int STALL_LIMIT   = 1000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES  = 40;    // cycles of watching for stray results at the end

    // Op codes with no function; the block must report the queue untouched.
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    logic i_clk;
    logic i_rst_n;

    bqi_in_if  in_ch ();
    bqi_out_if out_ch ();

    byte_queue_with_positional_insert #(
        .DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Words waiting to be driven, filled up front by the stimulus block.
    t_item         words_to_send[$];
    // Status words the block still owes, oldest first.
    t_result       status_due[$];
    // Behavioral copy of the queue contents, front at index 0.
    logic [7:0]    held_bytes[$];

    int            error_count  = 0;
    int            quiet_cycles = 0;
    int            burst_left   = 1;
    int            gap_left     = 0;
    int            rx_phase     = 0;
    int            rx_mode      = 0;

    t_item         sent_word;
    t_item         next_word;
    t_result       got_status;
    t_result       want_status;
    string         bad_fields;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Queue predictor: apply one word to the local copy and return the
    // status the block must report afterwards.
    // ------------------------------------------------------------------
    function automatic t_result step_byte_queue(t_item w);
        t_result st;
        int      at;
        logic    refused;

        refused = 1'b0;
        case (w.op)
            OP_APPEND, OP_FRONT, OP_INSERT: begin
                if (held_bytes.size() >= QUEUE_DEPTH) begin
                    // full: the insert is turned away, contents hold
                    refused = 1'b1;
                end else begin
                    if (w.op == OP_APPEND)
                        at = held_bytes.size();
                    else if (w.op == OP_FRONT)
                        at = 0;
                    else
                        at = int'(w.position);
                    // a position at or past the count lands at the rear
                    if (at > held_bytes.size())
                        at = held_bytes.size();
                    held_bytes.insert(at, w.value);
                end
            end
            OP_REMOVE: begin
                // removing from an empty queue is a no-op
                if (held_bytes.size() > 0)
                    void'(held_bytes.pop_front());
            end
            OP_CLEAR: begin
                held_bytes.delete();
            end
            default: begin
                // spare codes: leave the queue alone
            end
        endcase

        st.head_byte = (held_bytes.size() > 0) ? held_bytes[0] : 8'h00;
        st.empty_res = (held_bytes.size() == 0);
        st.entries   = CNT_OUT_W'(held_bytes.size());
        st.rejected  = refused;
        return st;
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endfunction

    task automatic add_word(logic [OP_W-1:0] op, logic [7:0] value, logic [7:0] position);
        t_item w;
        w.op       = op;
        w.value    = value;
        w.position = position;
        words_to_send.push_back(w);
    endtask

    // Pick an op for the random part: growing runs lean on inserts so the
    // queue reaches full often, shrinking runs lean on removes.
    function automatic logic [OP_W-1:0] pick_op(bit growing);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return OP_CLEAR;
        if (r < 4)
            return OP_RSVD5 + OP_W'($urandom_range(0, 2));
        if (growing) begin
            if (r < 30) return OP_APPEND;
            if (r < 50) return OP_FRONT;
            if (r < 88) return OP_INSERT;
            return OP_REMOVE;
        end
        if (r < 80) return OP_REMOVE;
        if (r < 88) return OP_APPEND;
        if (r < 93) return OP_FRONT;
        return OP_INSERT;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [OP_W-1:0] op;
        logic [7:0]      position;
        bit              growing;
        int              run_left;
        int              counted;

        // hold every input at a known value from time zero
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_APPEND;
        in_ch.value     = 8'h00;
        in_ch.position  = 8'h00;
        out_ch.ready    = 1'b0;

        // Directed part: spare code and remove on an empty queue, each kind
        // of insert with extreme bytes and positions, fill to full, then
        // every insert refused, spare codes on full, remove, clear.
        add_word(OP_RSVD7,  8'hFF, 8'hFF);
        add_word(OP_REMOVE, 8'hAA, 8'h00);
        add_word(OP_APPEND, 8'hFF, 8'h00);
        add_word(OP_FRONT,  8'h00, 8'hFF);
        add_word(OP_INSERT, 8'hA5, 8'd1);
        add_word(OP_INSERT, 8'h5A, 8'hFF);
        add_word(OP_INSERT, 8'h3C, 8'd0);
        add_word(OP_INSERT, 8'h81, 8'd5);    // position equal to count
        for (int i = 0; i < 10; i++)
            add_word(OP_INSERT, 8'($urandom_range(0, 255)), 8'(i));
        add_word(OP_APPEND, 8'h11, 8'h00);
        add_word(OP_FRONT,  8'h22, 8'h00);
        add_word(OP_INSERT, 8'h33, 8'h00);
        add_word(OP_RSVD5,  8'h00, 8'h00);
        add_word(OP_RSVD6,  8'hFF, 8'hFF);
        add_word(OP_REMOVE, 8'h00, 8'h00);
        add_word(OP_CLEAR,  8'hFF, 8'hFF);

        // Random part: runs of random length, each growing or shrinking at random.
        counted  = 0;
        run_left = 0;
        growing  = 1'b1;
        while (counted < RANDOM_WORDS) begin
            if (run_left == 0) begin
                growing  = ($urandom_range(0, 99) < 60);
                run_left = $urandom_range(5, 30);
            end
            run_left--;
            op = pick_op(growing);
            if ($urandom_range(0, 3) == 0)
                position = 8'($urandom_range(0, 255));
            else
                position = 8'($urandom_range(0, QUEUE_DEPTH + 1));
            add_word(op, 8'($urandom_range(0, 255)), position);
            if (op <= OP_CLEAR)
                counted++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every word is in and every status word is back
        while (words_to_send.size() != 0 || in_ch.valid || status_due.size() != 0)
            @(posedge i_clk);
        // keep watching for stray results
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (status_due.size() != 0)
            flag_error($sformatf("%0d status words never arrived", status_due.size()));
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: send words in bursts of random length with random gaps.
    // A new word goes out only when the previous one has been taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0 || words_to_send.size() == 0) begin
                in_ch.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end else begin
                next_word       = words_to_send.pop_front();
                in_ch.op       <= next_word.op;
                in_ch.value    <= next_word.value;
                in_ch.position <= next_word.position;
                in_ch.valid    <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    // end of burst: draw the next burst and the pause before it
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a mode that is redrawn at random during the run:
    // always ready, coin toss, one cycle in four, or an on/off cadence.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_phase++;
        if (rx_phase % 96 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= (rx_phase % 4 == 0);
            default: out_ch.ready <= (rx_phase % 7 < 4);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted input word, check every accepted
    // status word against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sent_word.op       = in_ch.op;
                sent_word.value    = in_ch.value;
                sent_word.position = in_ch.position;
                status_due.push_back(step_byte_queue(sent_word));
            end
            if (out_ch.valid && out_ch.ready) begin
                got_status.head_byte = out_ch.head_byte;
                got_status.empty_res = out_ch.empty_res;
                got_status.entries   = out_ch.entries;
                got_status.rejected  = out_ch.rejected;
                if (status_due.size() == 0) begin
                    flag_error($sformatf("%0t: status word with none expected: %p",
                                         $realtime, got_status));
                end else begin
                    want_status = status_due.pop_front();
                    bad_fields  = "";
                    if (got_status.head_byte !== want_status.head_byte)
                        bad_fields = {bad_fields, " head_byte"};
                    if (got_status.empty_res !== want_status.empty_res)
                        bad_fields = {bad_fields, " empty_res"};
                    if (got_status.entries !== want_status.entries)
                        bad_fields = {bad_fields, " entries"};
                    if (got_status.rejected !== want_status.rejected)
                        bad_fields = {bad_fields, " rejected"};
                    if (bad_fields != "")
                        flag_error($sformatf("%0t: mismatch in%s: expected %p, got %p",
                                             $realtime, bad_fields, want_status, got_status));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither side moves a word for too long.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/bqi_pkg.sv
rtl/bqi_if.sv
rtl/bqi_ram.sv
rtl/bqi_idx_unit.sv
rtl/bqi_seq.sv
rtl/byte_queue_with_positional_insert.sv
rtl/bqi_checker.sv
tb/testbench.sv
